FILE: hw/rtl/rtpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtpl_pkg;

  // fixed-point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int SAMPLE_W  = 37;
  localparam int CUT_W     = 17;
  localparam int RES_W     = 19;

  // stage values stay within +/- 1e6, which fits the sample width
  localparam int STAGE_W = SAMPLE_W;
  // multiplier operands: A carries the widest difference, B the coefficient
  localparam int OP_W    = 42;
  localparam int MB_W    = RES_W;
  localparam int PROD_W  = OP_W + MB_W;
  // running sums before saturation
  localparam int ACC_W   = 44;

  localparam longint ONE_FX = 64'sd1 <<< FRAC_BITS;

  localparam logic signed [CUT_W-1:0] CUT_MAX = CUT_W'((95 * ONE_FX + 50) / 100);
  localparam logic signed [RES_W-1:0] RES_MAX = RES_W'((398 * ONE_FX + 50) / 100);
  localparam logic signed [ACC_W-1:0] STAGE_LIMIT = ACC_W'(64'sd1000000 * ONE_FX);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RES,
    ST_DRIVE,
    ST_MUL_ONE,
    ST_UPD_ONE,
    ST_MUL_TWO,
    ST_UPD_TWO
  } rtpl_state_t;

  typedef struct packed {
    logic load;     // capture the input transaction
    logic mul_en;   // register a product
    logic mul_cut;  // product uses the cutoff and the difference operand
    logic drive;    // form drive minus stage one
    logic upd_one;  // form the new stage one and its difference to stage two
    logic upd_two;  // form stage two, saturate, load the output register
  } rtpl_cmd_t;

  function automatic logic signed [STAGE_W-1:0] saturate(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > STAGE_LIMIT) begin
      r = STAGE_LIMIT;
    end else if (v < -STAGE_LIMIT) begin
      r = -STAGE_LIMIT;
    end
    return r[STAGE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rtpl_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rtpl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rtpl_pkg::SAMPLE_W-1:0] sample_in;
  logic signed [rtpl_pkg::CUT_W-1:0]    cutoff;
  logic                                 first;

  modport source (output valid, output sample_in, output cutoff, output first, input ready);
  modport sink   (input valid, input sample_in, input cutoff, input first, output ready);
endinterface

interface rtpl_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rtpl_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rtpl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rtpl_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                out_ready,
  output logic                     in_ready,
  output logic                     out_valid,
  output rtpl_pkg::rtpl_cmd_t      cmd
);

  rtpl_pkg::rtpl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rtpl_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rtpl_pkg::ST_MUL_RES;
      end
      rtpl_pkg::ST_MUL_RES: state_nxt = rtpl_pkg::ST_DRIVE;
      rtpl_pkg::ST_DRIVE:   state_nxt = rtpl_pkg::ST_MUL_ONE;
      rtpl_pkg::ST_MUL_ONE: state_nxt = rtpl_pkg::ST_UPD_ONE;
      rtpl_pkg::ST_UPD_ONE: state_nxt = rtpl_pkg::ST_MUL_TWO;
      rtpl_pkg::ST_MUL_TWO: state_nxt = rtpl_pkg::ST_UPD_TWO;
      rtpl_pkg::ST_UPD_TWO: begin
        // hold until the output register can take the result
        if (out_free) state_nxt = rtpl_pkg::ST_IDLE;
      end
      default: state_nxt = rtpl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      rtpl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rtpl_pkg::ST_MUL_RES: cmd.mul_en = 1'b1;
      rtpl_pkg::ST_DRIVE:   cmd.drive = 1'b1;
      rtpl_pkg::ST_MUL_ONE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_cut = 1'b1;
      end
      rtpl_pkg::ST_UPD_ONE: cmd.upd_one = 1'b1;
      rtpl_pkg::ST_MUL_TWO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_cut = 1'b1;
      end
      rtpl_pkg::ST_UPD_TWO: cmd.upd_two = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.upd_two) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtpl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // one transaction at a time: no new input until the current one is finished
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a sample is in progress");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_two |-> out_free)
    else $error("output register overwritten");

  a_valid_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == rtpl_pkg::ST_UPD_TWO))
    else $error("result shown without a final update");

endmodule

`default_nettype wire

FILE: hw/rtl/rtpl_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rtpl_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire rtpl_pkg::rtpl_cmd_t                  cmd,
  input  wire logic                                 cfg_we,
  input  wire logic signed [rtpl_pkg::RES_W-1:0]    cfg_data,
  input  wire logic signed [rtpl_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic signed [rtpl_pkg::CUT_W-1:0]    cutoff,
  input  wire logic                                 first,
  output logic signed [rtpl_pkg::SAMPLE_W-1:0]      sample_out
);

  localparam int FRAC_BITS = rtpl_pkg::FRAC_BITS;
  localparam int SAMPLE_W  = rtpl_pkg::SAMPLE_W;
  localparam int CUT_W     = rtpl_pkg::CUT_W;
  localparam int RES_W     = rtpl_pkg::RES_W;
  localparam int STAGE_W   = rtpl_pkg::STAGE_W;
  localparam int OP_W      = rtpl_pkg::OP_W;
  localparam int MB_W      = rtpl_pkg::MB_W;
  localparam int PROD_W    = rtpl_pkg::PROD_W;
  localparam int ACC_W     = rtpl_pkg::ACC_W;

  logic signed [RES_W-1:0]    res_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [CUT_W-1:0]    ct_r;
  logic signed [RES_W-1:0]    rs_r;
  logic signed [STAGE_W-1:0]  s1_r, s2_r;
  logic signed [PROD_W-1:0]   p_r;
  logic signed [OP_W-1:0]     op_r;
  logic signed [ACC_W-1:0]    s1u_r;
  logic signed [SAMPLE_W-1:0] out_r;

  logic signed [OP_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   prod_shift;
  logic signed [ACC_W-1:0]    prod_fx;
  logic signed [ACC_W-1:0]    drive_diff;
  logic signed [ACC_W-1:0]    s1_new;
  logic signed [ACC_W-1:0]    s1_diff;
  logic signed [ACC_W-1:0]    s2_new;
  logic signed [STAGE_W-1:0]  s2_sat;

  // shared multiplier
  assign mul_a = cmd.mul_cut ? op_r : OP_W'(s2_r);
  assign mul_b = cmd.mul_cut ? MB_W'(ct_r) : rs_r;
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  // arithmetic shift floors toward minus infinity
  assign prod_shift = p_r >>> FRAC_BITS;
  assign prod_fx    = prod_shift[ACC_W-1:0];

  assign drive_diff = ACC_W'(x_r) - prod_fx - ACC_W'(s1_r);
  assign s1_new     = ACC_W'(s1_r) + prod_fx;
  assign s1_diff    = s1_new - ACC_W'(s2_r);
  assign s2_new     = ACC_W'(s2_r) + prod_fx;
  assign s2_sat     = rtpl_pkg::saturate(s2_new);

  assign sample_out = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
      s1_r  <= '0;
      s2_r  <= '0;
    end else begin
      if (cfg_we) res_r <= cfg_data;
      if (cmd.load && first) begin
        s1_r <= '0;
        s2_r <= '0;
      end else if (cmd.upd_two) begin
        s1_r <= rtpl_pkg::saturate(s1u_r);
        s2_r <= s2_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r  <= sample_in;
      ct_r <= (cutoff > rtpl_pkg::CUT_MAX) ? rtpl_pkg::CUT_MAX : cutoff;
      rs_r <= (res_r > rtpl_pkg::RES_MAX) ? rtpl_pkg::RES_MAX : res_r;
    end
    if (cmd.mul_en) p_r <= prod;
    if (cmd.drive) op_r <= drive_diff[OP_W-1:0];
    if (cmd.upd_one) begin
      s1u_r <= s1_new;
      op_r  <= s1_diff[OP_W-1:0];
    end
    if (cmd.upd_two) out_r <= s2_sat;
  end

  a_stage_one_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ACC_W'(s1_r) <= rtpl_pkg::STAGE_LIMIT && ACC_W'(s1_r) >= -rtpl_pkg::STAGE_LIMIT)
    else $error("stage one beyond saturation limit");

  a_stage_two_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ACC_W'(s2_r) <= rtpl_pkg::STAGE_LIMIT && ACC_W'(s2_r) >= -rtpl_pkg::STAGE_LIMIT)
    else $error("stage two beyond saturation limit");

  // the result leaves with the stage value it was computed from
  a_out_matches_stage: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_two |=> out_r == s2_r)
    else $error("output differs from stage two");

endmodule

`default_nettype wire

FILE: hw/rtl/resonant_two_pole_lowpass.sv
`timescale 1ns / 1ps
`default_nettype none

// Resonant two-pole low-pass, one audio sample per transaction.
// in_bus carries sample_in, cutoff and first; out_bus returns sample_out,
// the second stage after the update. cfg_valid/cfg_data write the
// resonance register, always ready; write it only while the filter is idle.
// All values are signed fixed point with 16 fraction bits.
// Sequence: a transaction is taken in the idle state; sample_out is valid
// once the filter is back in idle, where the next input can be taken, so
// one sample is in work at a time. The steps are set by the one shared
// multiplier that forms the resonance, stage-one and stage-two products in
// turn, each followed by an add step.
// A stalled receiver does not block the next input: the result sits in the
// output register and the next sample is accepted and computed, then waits
// in its final step until the output register is taken.
// Reset (rst_n low, synchronous) clears both filter stages, the resonance
// register and any pending result.
module resonant_two_pole_lowpass (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  rtpl_in_if.sink                                   in_bus,
  rtpl_out_if.source                                out_bus,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic signed [rtpl_pkg::RES_W-1:0]    cfg_data
);

  rtpl_pkg::rtpl_cmd_t cmd;
  logic                in_ready;
  logic                out_valid;

  assign cfg_ready     = 1'b1;
  assign in_bus.ready  = in_ready;
  assign out_bus.valid = out_valid;

  rtpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .out_ready (out_bus.ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  rtpl_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .sample_in  (in_bus.sample_in),
    .cutoff     (in_bus.cutoff),
    .first      (in_bus.first),
    .sample_out (out_bus.sample_out)
  );

endmodule

`default_nettype wire
